>>> src/bpe_pkg.sv
// shared types, constants and helper functions of the bezier point evaluator
package bpe_pkg;

	localparam int DEGREE      = 7;
	localparam int SEGMENTS    = 16;
	localparam int AXES        = 3;
	localparam int NPTS        = DEGREE + 1;
	localparam int STORE_DEPTH = SEGMENTS * AXES * NPTS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int J_W         = (NPTS > 1) ? $clog2(NPTS) : 1;
	localparam int BINOM_W     = 16;
	localparam int T_W         = 17;
	localparam int COORD_W     = 32;
	localparam int POW_W       = 2 * T_W;
	localparam int PP_W        = POW_W + BINOM_W;
	localparam int PROD_W      = COORD_W + T_W + 1;
	localparam int ACC_W       = PROD_W + J_W + 1;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

	typedef enum logic [1:0] {
		CMD_WR   = 2'd0,
		CMD_EVAL = 2'd1,
		CMD_ZERO = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [COORD_W-1:0]  data;
		logic [T_W-1:0]      t;
	} cmd_t;

	typedef logic [BINOM_W-1:0] binom_tbl_t [NPTS];

	function automatic binom_tbl_t binom_row();
		binom_tbl_t row;
		int n;
		int k;
		for (k = 0; k < NPTS; k++) row[k] = '0;
		row[0] = BINOM_W'(1);
		for (n = 1; n <= DEGREE; n++) begin
			for (k = n; k >= 1; k--) row[k] = row[k] + row[k-1];
		end
		return row;
	endfunction

	localparam binom_tbl_t BINOM = binom_row();

endpackage

>>> src/bpe_front.sv
// front end: takes input transactions, checks addresses and builds queue commands
module bpe_front import bpe_pkg::*; (
	input  logic                mode,
	input  logic [3:0]          segment,
	input  logic [1:0]          axis,
	input  logic [2:0]          point_index,
	input  logic [COORD_W-1:0]  coord_value,
	input  logic [T_W-1:0]      param_t,
	output logic                push_ok,
	output cmd_t                cmd
);

	logic seg_ok;
	logic wr_ok;
	logic [ADDR_W-1:0] row_base;

	assign seg_ok   = 32'(segment) < SEGMENTS;
	assign wr_ok    = seg_ok && (32'(axis) < AXES) && (32'(point_index) <= DEGREE);
	assign row_base = ADDR_W'((32'(segment) * AXES + (mode ? 32'd0 : 32'(axis))) * NPTS);

	always_comb begin
		cmd.data = coord_value;
		cmd.t    = (param_t > ONE_Q16) ? ONE_Q16 : param_t;
		if (!mode) begin
			cmd.kind = CMD_WR;
			cmd.addr = row_base + ADDR_W'(point_index);
			push_ok  = wr_ok;
		end else begin
			cmd.kind = seg_ok ? CMD_EVAL : CMD_ZERO;
			cmd.addr = row_base;
			push_ok  = 1'b1;
		end
	end

endmodule

>>> src/bpe_queue.sv
// small command queue between the front end and the evaluation engine
module bpe_queue import bpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cmd_t             push_cmd,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output cmd_t             pop_cmd,
	output logic [QPTR_W:0]  level
);

	cmd_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full      = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign level     = cnt_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> src/bpe_back.sv
// evaluation engine: control point store, bernstein basis and shared multiply-accumulate
module bpe_back import bpe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [COORD_W-1:0]  m_x,
	output logic [COORD_W-1:0]  m_y,
	output logic [COORD_W-1:0]  m_z,
	output logic                m_ovf
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_POW   = 7'b0000010,
		ST_BAS_A = 7'b0000100,
		ST_BAS_B = 7'b0001000,
		ST_MAC   = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	localparam logic [J_W-1:0] J_LAST  = J_W'(DEGREE);
	localparam logic [1:0]     AX_LAST = 2'(AXES - 1);

	state_t state_q;

	logic [COORD_W-1:0] mem [STORE_DEPTH];

	logic [T_W-1:0]     t_q;
	logic [T_W-1:0]     u_q;
	logic [T_W-1:0]     tp_q;
	logic [T_W-1:0]     up_q;
	logic [T_W-1:0]     tp_arr_q [NPTS];
	logic [T_W-1:0]     up_arr_q [NPTS];
	logic [T_W-1:0]     basis_q  [NPTS];
	logic [POW_W-1:0]   pp_q;
	logic [J_W-1:0]     j_q;
	logic [1:0]         ax_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  rd_addr_q;

	logic               v_s1;
	logic [J_W-1:0]     j_s1;
	logic [1:0]         ax_s1;
	logic [COORD_W-1:0] rdata_s1;
	logic               v_s2;
	logic               last_s2;
	logic [1:0]         ax_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_nxt;
	logic signed [ACC_W-1:0] acc_sh;
	logic [COORD_W-1:0]      res_q [AXES];
	logic                    ovf_q;
	logic                    sat_hi;
	logic                    sat_lo;

	logic               m_valid_q;
	logic [COORD_W-1:0] m_x_q;
	logic [COORD_W-1:0] m_y_q;
	logic [COORD_W-1:0] m_z_q;
	logic               m_ovf_q;

	logic [T_W-1:0]     tp_nxt;
	logic [T_W-1:0]     up_nxt;
	logic [T_W-1:0]     basis_nxt;
	logic               fin;
	logic               load_out;

	localparam logic signed [ACC_W-1:0] RND     = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] MAX_I32 = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] MIN_I32 = ACC_W'(-64'sd2147483648);

	assign cmd_ready = state_q == ST_IDLE;
	assign tp_nxt    = T_W'(((POW_W+1)'(tp_q) * (POW_W+1)'(t_q) + (POW_W+1)'(32768)) >> 16);
	assign up_nxt    = T_W'(((POW_W+1)'(up_q) * (POW_W+1)'(u_q) + (POW_W+1)'(32768)) >> 16);
	assign basis_nxt = T_W'((PP_W'(pp_q) * PP_W'(BINOM[j_q]) + PP_W'(64'h80000000)) >> 32);

	assign acc_nxt = acc_q + ACC_W'(prod_s2);
	assign acc_sh  = acc_nxt >>> 16;
	assign sat_hi  = acc_sh > MAX_I32;
	assign sat_lo  = acc_sh < MIN_I32;
	assign fin     = v_s2 && last_s2 && (ax_s2 == AX_LAST);
	assign load_out = (state_q == ST_DONE) && (!m_valid_q || m_ready);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd.kind == CMD_WR) mem[cmd.addr] <= cmd.data;
		rdata_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_MAC;
			v_s2 <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_EVAL: state_q <= ST_POW;
							CMD_ZERO: state_q <= ST_DONE;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_POW: begin
					if (j_q == J_LAST) state_q <= ST_BAS_A;
				end
				ST_BAS_A: state_q <= ST_BAS_B;
				ST_BAS_B: begin
					state_q <= (j_q == J_LAST) ? ST_MAC : ST_BAS_A;
				end
				ST_MAC: begin
					if (j_q == J_LAST && ax_q == AX_LAST) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (fin) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= j_q;
		ax_s1   <= ax_q;
		prod_s2 <= $signed({{(PROD_W-COORD_W){rdata_s1[COORD_W-1]}}, rdata_s1})
			* $signed(PROD_W'(basis_q[j_s1]));
		last_s2 <= j_s1 == J_LAST;
		ax_s2   <= ax_s1;
		case (state_q)
			ST_IDLE: begin
				t_q         <= cmd.t;
				u_q         <= ONE_Q16 - cmd.t;
				tp_q        <= ONE_Q16;
				up_q        <= ONE_Q16;
				tp_arr_q[0] <= ONE_Q16;
				up_arr_q[0] <= ONE_Q16;
				j_q         <= J_W'(1);
				base_q      <= cmd.addr;
				acc_q       <= RND;
				ovf_q       <= 1'b0;
				if (cmd.kind == CMD_ZERO) begin
					for (int a = 0; a < AXES; a++) res_q[a] <= '0;
				end
			end
			ST_POW: begin
				tp_q           <= tp_nxt;
				up_q           <= up_nxt;
				tp_arr_q[j_q]  <= tp_nxt;
				up_arr_q[j_q]  <= up_nxt;
				j_q            <= (j_q == J_LAST) ? '0 : j_q + 1'b1;
			end
			ST_BAS_A: begin
				pp_q <= POW_W'(tp_arr_q[j_q]) * POW_W'(up_arr_q[J_LAST - j_q]);
			end
			ST_BAS_B: begin
				basis_q[j_q] <= basis_nxt;
				j_q          <= (j_q == J_LAST) ? '0 : j_q + 1'b1;
				ax_q         <= '0;
				rd_addr_q    <= base_q;
			end
			ST_MAC: begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (j_q == J_LAST) begin
					j_q  <= '0;
					ax_q <= ax_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (v_s2) begin
			if (last_s2) begin
				acc_q <= RND;
				res_q[ax_s2] <= sat_hi ? COORD_W'(MAX_I32) :
					sat_lo ? COORD_W'(MIN_I32) : COORD_W'(acc_sh);
				ovf_q <= ovf_q | sat_hi | sat_lo;
			end else begin
				acc_q <= acc_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_x_q   <= res_q[0];
			m_y_q   <= res_q[1];
			m_z_q   <= res_q[2];
			m_ovf_q <= ovf_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_x     = m_x_q;
	assign m_y     = m_y_q;
	assign m_z     = m_z_q;
	assign m_ovf   = m_ovf_q;

endmodule

>>> src/bezier_point_evaluator.sv
// top level of the bezier point evaluator
// Evaluates a 3D piecewise Bezier trajectory (degree 7, 16 segments) in fixed point.
// A transaction with tuser 0 writes one control-point coordinate; a transaction
// with tuser 1 evaluates x, y and z at parameter t and returns one result
// transaction. An evaluation occupies the engine for the power walk, a multiply
// and a scaling state per basis term (ST_BAS_A, ST_BAS_B), and one shared
// multiply-accumulate stepping through the 24 stored points, one memory read a
// cycle. A 4-entry command queue lets inputs be taken while the engine works and
// while a result waits to be taken. Evaluation of a segment never written gives
// undefined coordinates.
module bezier_point_evaluator import bpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // segment, axis, point_index, coord_value, param_t, zero fill
	input  logic [0:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // pos_x, pos_y, pos_z
	output logic [0:0]  m_tuser    // overflow
);

	cmd_t              front_cmd;
	cmd_t              q_cmd;
	logic              push_ok;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [QPTR_W:0]   q_level;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [COORD_W-1:0] pos_z;
	logic              ovf;

	assign s_tready = !q_full;

	bpe_front u_front (
		.mode        (s_tuser[0]),
		.segment     (s_tdata[3:0]),
		.axis        (s_tdata[5:4]),
		.point_index (s_tdata[8:6]),
		.coord_value (s_tdata[40:9]),
		.param_t     (s_tdata[57:41]),
		.push_ok     (push_ok),
		.cmd         (front_cmd)
	);

	bpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && push_ok),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (q_cmd),
		.level     (q_level)
	);

	bpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_pop),
		.cmd       (q_cmd),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_x       (pos_x),
		.m_y       (pos_y),
		.m_z       (pos_z),
		.m_ovf     (ovf)
	);

	assign m_tdata = {pos_z, pos_y, pos_x};
	assign m_tuser = ovf;

`ifndef SYNTH
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			pos_x == 32'h7fffffff || pos_x == 32'h80000000 ||
			pos_y == 32'h7fffffff || pos_y == 32'h80000000 ||
			pos_z == 32'h7fffffff || pos_z == 32'h80000000)
		else $error("overflow flagged without a saturated coordinate");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_level == '0 |-> s_tready && !q_valid)
		else $error("empty queue must accept and offer nothing");
`endif

endmodule

>>> dv/tb_bezier_point_evaluator.sv
// testbench of the bezier point evaluator: directed and random writes and evaluations, and output backpressure
`timescale 1ns / 100ps

module tb_bezier_point_evaluator import bpe_pkg::*;;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        ovf;
	} point_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [0:0]  m_tuser;

	bezier_point_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	logic signed [31:0] shadow_pts [STORE_DEPTH];
	point_t             pending_points [$];
	int                 errors;
	int                 hold_cycles;
	bit                 rx_random;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("bezier_point_evaluator regression: fail");
		$finish;
	end

	function automatic longint unsigned binom7(int j);
		longint unsigned c;
		c = 1;
		for (int k = 0; k < j; k++) c = c * (DEGREE - k) / (k + 1);
		return c;
	endfunction

	function automatic logic [31:0] sat_coord(longint signed v, ref bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic point_t eval_point(int seg, logic [16:0] t_in);
		longint unsigned tp [NPTS];
		longint unsigned up [NPTS];
		longint unsigned basis [NPTS];
		longint unsigned t;
		longint signed acc;
		logic [31:0] r [3];
		bit ovf;
		point_t p;
		ovf = 0;
		if (seg >= SEGMENTS) return '0;
		t = (t_in > 17'd65536) ? 65536 : t_in;
		tp[0] = 65536;
		up[0] = 65536;
		for (int j = 1; j < NPTS; j++) begin
			tp[j] = (tp[j-1] * t + 32768) >> 16;
			up[j] = (up[j-1] * (65536 - t) + 32768) >> 16;
		end
		for (int j = 0; j < NPTS; j++)
			basis[j] = (binom7(j) * tp[j] * up[DEGREE-j] + 64'h80000000) >> 32;
		for (int a = 0; a < 3; a++) begin
			acc = 0;
			for (int j = 0; j < NPTS; j++)
				acc += longint'(shadow_pts[(seg*3+a)*NPTS+j]) * longint'(basis[j]);
			r[a] = sat_coord((acc + 32768) >>> 16, ovf);
		end
		p.px = r[0];
		p.py = r[1];
		p.pz = r[2];
		p.ovf = ovf;
		return p;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_item(bit mode, int seg, int axis, int pidx, logic [31:0] val,
			logic [16:0] t, bit gaps);
		int gap;
		gap = gaps ? rand_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, t, val, 3'(pidx), 2'(axis), 4'(seg)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == 1'b0) begin
			if (axis < 3 && seg < SEGMENTS && pidx <= DEGREE)
				shadow_pts[(seg*3+axis)*NPTS+pidx] = val;
		end else begin
			pending_points.insert(pending_points.size(), eval_point(seg, t));
		end
	endtask

	task automatic load_segment(int seg, bit extreme, bit gaps);
		logic [31:0] v;
		for (int a = 0; a < 3; a++)
			for (int j = 0; j < NPTS; j++) begin
				case ($urandom_range(0, extreme ? 2 : 5))
					0: v = 32'h7fffffff;
					1: v = 32'h80000000;
					default: v = $urandom;
				endcase
				if (!extreme && $urandom_range(0, 1)) v = $signed(v) >>> $urandom_range(4, 14);
				send_item(1'b0, seg, a, j, v, 17'($urandom), gaps);
			end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_directed();
		load_segment(0, 1'b0, 1'b0);
		load_segment(15, 1'b1, 1'b0);
		send_item(1'b1, 0, 0, 0, '0, 17'd0, 1'b0);
		send_item(1'b1, 0, 3, 7, 32'hffffffff, 17'd65536, 1'b0);
		send_item(1'b1, 0, 0, 0, '0, 17'd32768, 1'b0);
		send_item(1'b1, 15, 0, 0, '0, 17'd1, 1'b0);
		send_item(1'b1, 15, 0, 0, '0, 17'h1ffff, 1'b0);
		send_item(1'b1, 15, 0, 0, '0, 17'd65535, 1'b0);
		send_item(1'b0, 0, 3, 0, 32'h12345678, 17'd0, 1'b0);
		drain();
	endtask

	task automatic test_random();
		int seg;
		int n;
		n = 0;
		for (int s = 1; s < 15; s++) load_segment(s, $urandom_range(0, 3) == 0, 1'b1);
		while (n < 1500) begin
			seg = $urandom_range(0, 15);
			case ($urandom_range(0, 9))
				0: send_item(1'b0, seg, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom, 17'($urandom), 1'b1);
				1: send_item(1'b1, seg, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom, 17'($urandom_range(65537, 131071)), 1'b1);
				default: send_item(1'b1, seg, $urandom_range(0, 3), $urandom_range(0, 7),
						$urandom, 17'($urandom_range(0, 65536)), 1'b1);
			endcase
			n++;
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 12; i++)
			send_item(1'b1, $urandom_range(0, 15), 0, 0, '0, 17'($urandom_range(0, 65536)), 1'b0);
		drain();
		rx_random = 0;
		for (int i = 0; i < 20; i++)
			send_item(1'b1, $urandom_range(0, 15), 0, 0, '0, 17'($urandom_range(0, 65536)), 1'b0);
		drain();
		rx_random = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (!rx_random) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[31:0] !== want.px) begin
					$error("pos_x expected %h actual %h", want.px, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== want.py) begin
					$error("pos_y expected %h actual %h", want.py, m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== want.pz) begin
					$error("pos_z expected %h actual %h", want.pz, m_tdata[95:64]);
					errors++;
				end
				if (m_tuser[0] !== want.ovf) begin
					$error("overflow expected %b actual %b", want.ovf, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		hold_cycles = 0;
		rx_random = 1;
		for (int i = 0; i < STORE_DEPTH; i++) shadow_pts[i] = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		if (pending_points.size() != 0) begin
			$error("results still expected at end");
			errors++;
		end
		if (errors == 0) begin
			$display("bezier_point_evaluator regression: pass");
		end else begin
			$display("bezier_point_evaluator regression: fail");
		end
		$finish;
	end

endmodule
